// ===== rtl/core/apq_pkg.sv =====
package apq_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PrioW  = 8;
  localparam int unsigned OccW   = 5;

  localparam logic [PrioW-1:0] MaxPrioReset = 8'd10;
  localparam logic [PrioW-1:0] PrioSat      = 8'd255;
  localparam logic [PrioW-1:0] AgeStep      = 8'd1;

  typedef enum logic [0:0] {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ENQ   = 3'd0,
    ST_DEQ   = 3'd1,
    ST_EMPTY = 3'd2,
    ST_RANGE = 3'd3,
    ST_FULL  = 3'd4
  } status_e;

  typedef struct packed {
    cmd_e                     command;
    logic signed [ValueW-1:0] value;
    logic        [PrioW-1:0]  priority_req;
  } in_t;

  typedef struct packed {
    logic signed [ValueW-1:0] result_value;
    status_e                  status;
    logic        [OccW-1:0]   occupancy;
  } out_t;

  // One slot of the queue.
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic        [PrioW-1:0]  prio;
  } entry_t;

  // Broadcast to every cell for the beat being accepted.
  typedef struct packed {
    logic                     enq;
    logic                     deq;
    logic signed [ValueW-1:0] value;
    logic        [PrioW-1:0]  prio;
  } cell_ctl_t;

endpackage

// ===== rtl/core/aging_priority_queue_top.sv =====
// Priority queue with aging, up to DEPTH entries held sorted by priority.
// Input channel (in_valid_i / in_stall_o / in_i): one beat is an enqueue
// (value and priority) or a dequeue. Output channel (out_valid_o /
// out_stall_i / out_o): exactly one result beat per input beat, in order,
// carrying the dequeued value (zero otherwise), a status code and the
// occupancy after the operation.
// Configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes
// max_priority; it is always ready and is meant to be written while idle.
// The result is registered at the edge that takes the beat. Throughput is one
// beat per cycle while no result is stalled: every slot is a cell that compares
// and shifts in parallel, so an insert or a remove-and-age finishes in a
// single update of the cell row.
// When out_stall_i holds a waiting result, in_stall_o rises and input beats
// are held off until the result is taken.
// Reset empties the queue, clears the output valid and sets max_priority to
// 10. Slot contents are not cleared; only occupied slots are ever read.
module aging_priority_queue_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  apq_pkg::in_t                     in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output apq_pkg::out_t                    out_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [apq_pkg::PrioW-1:0]        cfg_data_i
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]           count_q, count_d;
  logic [apq_pkg::PrioW-1:0] max_prio_q;
  logic                      out_valid_q;
  apq_pkg::out_t             out_q, out_d;

  logic               accept;
  logic               is_full, is_empty, out_of_range;
  apq_pkg::cell_ctl_t ctl;

  apq_pkg::entry_t ent  [DEPTH];
  logic            take [DEPTH];

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign is_full      = (count_q == CntW'(DEPTH));
  assign is_empty     = (count_q == '0);
  assign out_of_range = (in_i.priority_req > max_prio_q);

  always_comb begin
    ctl.enq   = accept && (in_i.command == apq_pkg::CMD_ENQ) && !out_of_range && !is_full;
    ctl.deq   = accept && (in_i.command == apq_pkg::CMD_DEQ) && !is_empty;
    ctl.value = in_i.value;
    ctl.prio  = in_i.priority_req;
  end

  always_comb begin
    count_d = count_q;
    if (ctl.enq) begin
      count_d = count_q + CntW'(1);
    end else if (ctl.deq) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    out_d.result_value = '0;
    out_d.occupancy    = apq_pkg::OccW'(count_d);
    if (in_i.command == apq_pkg::CMD_ENQ) begin
      if (out_of_range) begin
        out_d.status = apq_pkg::ST_RANGE;
      end else if (is_full) begin
        out_d.status = apq_pkg::ST_FULL;
      end else begin
        out_d.status = apq_pkg::ST_ENQ;
      end
    end else if (is_empty) begin
      out_d.status = apq_pkg::ST_EMPTY;
    end else begin
      out_d.status       = apq_pkg::ST_DEQ;
      out_d.result_value = ent[0].value;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic            occ;
    logic            left_take;
    apq_pkg::entry_t left_ent, right_ent;

    assign occ = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_take = 1'b0;
      assign left_ent  = '0;
    end else begin : g_body
      assign left_take = take[i-1];
      assign left_ent  = ent[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end

    apq_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .occ_i       (occ),
      .left_take_i (left_take),
      .left_ent_i  (left_ent),
      .right_ent_i (right_ent),
      .take_o      (take[i]),
      .ent_o       (ent[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      max_prio_q  <= apq_pkg::MaxPrioReset;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_prio_q <= cfg_data_i;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/core/apq_cell.sv =====
module apq_cell (
  input  logic               clk_i,
  input  apq_pkg::cell_ctl_t ctl_i,
  input  logic               occ_i,
  input  logic               left_take_i,
  input  apq_pkg::entry_t    left_ent_i,
  input  apq_pkg::entry_t    right_ent_i,
  output logic               take_o,
  output apq_pkg::entry_t    ent_o
);

  apq_pkg::entry_t ent_q, ent_d;

  // New entry lands in the first slot that is empty or holds a lower priority.
  assign take_o = !(occ_i && (ent_q.prio >= ctl_i.prio));
  assign ent_o  = ent_q;

  always_comb begin
    ent_d = ent_q;
    if (ctl_i.enq) begin
      if (left_take_i) begin
        ent_d = left_ent_i;
      end else if (take_o) begin
        ent_d.value = ctl_i.value;
        ent_d.prio  = ctl_i.prio;
      end
    end else if (ctl_i.deq) begin
      // Advance toward the front and age by one, saturating.
      ent_d.value = right_ent_i.value;
      ent_d.prio  = (right_ent_i.prio == apq_pkg::PrioSat) ? apq_pkg::PrioSat
                  : right_ent_i.prio + apq_pkg::AgeStep;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

// ===== rtl/core/apq_checker.sv =====
module apq_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input apq_pkg::out_t out_o
);

  // Stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed");

  // Every accepted input beat yields a result on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted beat produced no result");

  // Input is held off only behind a waiting result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a pending result");

  // Only a successful dequeue returns a value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status != apq_pkg::ST_DEQ) |-> out_o.result_value == '0)
    else $error("nonzero value on non-dequeue result");

  // Empty and full reports agree with occupancy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((out_o.status != apq_pkg::ST_EMPTY) || (out_o.occupancy == '0))
      && ((out_o.status != apq_pkg::ST_FULL)
          || (out_o.occupancy == apq_pkg::OccW'(DEPTH))))
    else $error("occupancy disagrees with empty/full status");

endmodule

bind aging_priority_queue_top apq_checker #(.DEPTH(DEPTH)) u_apq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);
